/* design/tmvw_pkg.sv */
// ----------------------------------------------------------------------------
// Tile map viewport walker package
// Shared constants, codes and item types for the tile map and its row walker.
// ----------------------------------------------------------------------------
package tmvw_pkg;

  // Map geometry. Both sizes are powers of two, so wrapping a signed tile
  // coordinate keeps its low bits.
  localparam int MAP_COLS  = 128;
  localparam int MAP_ROWS  = 128;
  localparam int COL_W     = $clog2(MAP_COLS);
  localparam int ROW_W     = $clog2(MAP_ROWS);
  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int TILE_BITS = 8;

  // Tiles are eight by eight pixels.
  localparam int TILE_PIX = 8;

  localparam logic [TILE_BITS-1:0] EMPTY_TILE = 8'hFF;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_RECT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam int REG_INDEX_W = 3;
  localparam logic [REG_INDEX_W-1:0] REG_SCREEN_X    = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SCREEN_Y    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_SCROLL_X    = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_SCROLL_Y    = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_DRAW_MASK   = 3'd6;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]           operation;
    logic signed [15:0]   tile_col;
    logic signed [15:0]   tile_row;
    logic [TILE_BITS-1:0] tile_value;
    logic [5:0]           view_row;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TILE_BITS-1:0] read_tile;
    logic signed [15:0]   dest_x;
    logic signed [15:0]   dest_y;
    logic [TILE_BITS-1:0] sprite_index;
    logic [2:0]           src_x;
    logic [2:0]           src_y;
    logic [3:0]           rect_w;
    logic [3:0]           rect_h;
    logic [15:0]          mask_out;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic signed [14:0] screen_x;
    logic signed [14:0] screen_y;
    logic [8:0]         view_width;
    logic [8:0]         view_height;
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;
    logic [15:0]        draw_mask;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [TILE_BITS-1:0] wdata;
  } ram_req_t;

  // Pixel coordinates inside the viewport, wide enough for -8 .. 1023.
  typedef logic signed [10:0] coord_t;

endpackage

/* design/tmvw_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module tmvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/tmvw_walker.sv */
// ----------------------------------------------------------------------------
// Tile map walker
// Sequences tile writes, reads and row draws against the tile RAM.
// ----------------------------------------------------------------------------
module tmvw_walker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  tmvw_pkg::cmd_t                  cmd,
  input  tmvw_pkg::cfg_t                  cfg,
  output tmvw_pkg::ram_req_t              ram_req,
  input  logic [tmvw_pkg::TILE_BITS-1:0]  ram_rdata,
  output logic                            result_strobe,
  output tmvw_pkg::res_t                  result
);
  import tmvw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDATA  = 5'b00010,
    S_SETUP  = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [ROW_W-1:0] row_addr;
  logic [COL_W-1:0] col_base;
  logic [5:0]       vrow;
  logic [6:0]       k;
  logic [6:0]       rd_k;
  logic             rd_valid;
  logic             pending_valid;
  res_t             pending;

  logic signed [15:0] row_dest_y;
  logic [2:0]         row_src_y;
  logic [3:0]         row_h;

  coord_t vw_s, vh_s;
  coord_t y0, y1, y2a, y2;
  coord_t x0k, x0c, x1c, x2a, x2c;
  logic   row_visible;
  logic   issue;
  logic   tile_ok;
  res_t   rect;
  res_t   read_res;
  res_t   marker_res;
  res_t   final_res;

  assign busy = (state != S_IDLE);

  assign vw_s = $signed({2'b00, cfg.view_width});
  assign vh_s = $signed({2'b00, cfg.view_height});

  // Top edge of the requested tile row relative to the viewport.
  always_comb begin
    y0  = $signed({2'b00, vrow, 3'b000}) - $signed({8'b0, cfg.scroll_y[2:0]});
    y1  = y0[10] ? '0 : y0;
    y2a = y0 + coord_t'(TILE_PIX);
    y2  = (y2a >= vh_s) ? vh_s : y2a;
    row_visible = (y0 < vh_s);
  end

  // Column being fetched and column whose tile code is on the RAM output.
  always_comb begin
    x0k   = $signed({1'b0, k, 3'b000}) - $signed({8'b0, cfg.scroll_x[2:0]});
    issue = (x0k < vw_s);
    x0c   = $signed({1'b0, rd_k, 3'b000}) - $signed({8'b0, cfg.scroll_x[2:0]});
    x1c   = x0c[10] ? '0 : x0c;
    x2a   = x0c + coord_t'(TILE_PIX);
    x2c   = (x2a >= vw_s) ? vw_s : x2a;
    tile_ok = rd_valid && (ram_rdata != EMPTY_TILE);
  end

  always_comb begin
    rect              = '0;
    rect.kind         = KIND_RECT;
    rect.dest_x       = $signed({cfg.screen_x[14], cfg.screen_x})
                        + $signed({6'b0, x1c[9:0]});
    rect.dest_y       = row_dest_y;
    rect.sprite_index = ram_rdata;
    rect.src_x        = 3'(x1c - x0c);
    rect.src_y        = row_src_y;
    rect.rect_w       = 4'(x2c - x1c);
    rect.rect_h       = row_h;
    rect.mask_out     = cfg.draw_mask;
    rect.last         = 1'b0;
  end

  // Whole result items for a read, an empty row and the final rectangle.
  always_comb begin
    read_res           = '0;
    read_res.kind      = KIND_READ;
    read_res.read_tile = ram_rdata;
    read_res.last      = 1'b1;
    marker_res         = '0;
    marker_res.kind    = KIND_EMPTY;
    marker_res.last    = 1'b1;
    final_res          = pending;
    final_res.last     = 1'b1;
  end

  // RAM port: the command addresses it directly while idle, the walker
  // otherwise.
  always_comb begin
    if (state == S_IDLE) begin
      ram_req.we    = start && (cmd.operation == OP_WRITE);
      ram_req.addr  = {cmd.tile_row[ROW_W-1:0], cmd.tile_col[COL_W-1:0]};
      ram_req.wdata = cmd.tile_value;
    end else begin
      ram_req.we    = 1'b0;
      ram_req.addr  = {row_addr, col_base + COL_W'(k)};
      ram_req.wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_valid      <= 1'b0;
      pending_valid <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.operation == OP_READ) begin
              state <= S_RDATA;
            end else if (cmd.operation == OP_DRAW) begin
              row_addr      <= cfg.scroll_y[ROW_W+2:3] + ROW_W'(cmd.view_row);
              col_base      <= cfg.scroll_x[COL_W+2:3];
              vrow          <= cmd.view_row;
              pending_valid <= 1'b0;
              state         <= S_SETUP;
            end
          end
        end
        S_RDATA: begin
          result        <= read_res;
          result_strobe <= 1'b1;
          state         <= S_IDLE;
        end
        S_SETUP: begin
          row_dest_y <= $signed({cfg.screen_y[14], cfg.screen_y})
                        + $signed({6'b0, y1[9:0]});
          row_src_y  <= 3'(y1 - y0);
          row_h      <= 4'(y2 - y1);
          k          <= '0;
          rd_valid   <= 1'b0;
          state      <= row_visible ? S_WALK : S_FINISH;
        end
        S_WALK: begin
          rd_valid <= issue;
          rd_k     <= k;
          if (issue) begin
            k <= k + 7'd1;
          end
          // Hold back the newest rectangle so the final one can carry last.
          if (tile_ok) begin
            if (pending_valid) begin
              result        <= pending;
              result_strobe <= 1'b1;
            end
            pending       <= rect;
            pending_valid <= 1'b1;
          end
          if (!issue && !rd_valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          result        <= pending_valid ? final_res : marker_res;
          result_strobe <= 1'b1;
          pending_valid <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/tile_map_viewport_walker.sv */
// ----------------------------------------------------------------------------
// Tile map viewport walker
// Wrapping 128 x 128 tile map with a scrolled viewport row renderer.
// ----------------------------------------------------------------------------
// A write goes to the RAM as it is accepted; a read item is registered in
// the S_RDATA state. A row draw runs setup, one RAM read per visible tile
// column (up to 65; 16 or 17 for a 128-pixel viewport) and a finish, the
// single RAM port being the limiting resource. One item is in work at once.
// Results cannot be stalled by the receiver. Reset clears the sequencer and
// restores the register defaults; the tile map itself is not cleared.
module tile_map_viewport_walker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  tmvw_pkg::cmd_t                       cmd,
  output logic                                 result_strobe,
  output tmvw_pkg::res_t                       result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmvw_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [tmvw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tmvw_pkg::*;

  cfg_t                 cfg;
  ram_req_t             ram_req;
  logic [TILE_BITS-1:0] ram_rdata;

  // The register file can always take a write; writes are expected only
  // while the block is idle, so no interlock with the walker is needed.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_x    <= '0;
      cfg.screen_y    <= '0;
      cfg.view_width  <= 9'd128;
      cfg.view_height <= 9'd128;
      cfg.scroll_x    <= '0;
      cfg.scroll_y    <= '0;
      cfg.draw_mask   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes beyond the register list are ignored.
      unique case (cfg_index)
        REG_SCREEN_X:    cfg.screen_x    <= $signed(cfg_data[14:0]);
        REG_SCREEN_Y:    cfg.screen_y    <= $signed(cfg_data[14:0]);
        REG_VIEW_WIDTH:  cfg.view_width  <= cfg_data[8:0];
        REG_VIEW_HEIGHT: cfg.view_height <= cfg_data[8:0];
        REG_SCROLL_X:    cfg.scroll_x    <= $signed(cfg_data);
        REG_SCROLL_Y:    cfg.scroll_y    <= $signed(cfg_data);
        REG_DRAW_MASK:   cfg.draw_mask   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The tile map: one byte per tile, addressed by wrapped row and column.
  tmvw_ram #(
    .WIDTH (TILE_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // The sequencer streams one column read per cycle and clips each tile
  // against the viewport as its code returns from the RAM.
  tmvw_walker u_walker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .cfg           (cfg),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map viewport walker testbench
// Fills one row of the wrapping tile map, then drives tile writes, tile reads
// and viewport row draws under a range of viewport settings. A behavioural
// copy of the map and the row walk predicts every result item, which is
// checked field by field against what the block emits, in order.
// ----------------------------------------------------------------------------
module tb_top;

  import tmvw_pkg::*;

  // At most this many rectangles come from one row draw of a viewport up to 504 wide.
  localparam int MAX_ROW_RECTS = 64;
  // Register index past the end of the register list; writes to it are dropped.
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  // Operation code with no meaning; the block swallows such items.
  localparam logic [1:0] OP_NONE = 2'd3;
  // A row draw of a 504-pixel viewport finishes well within this; allow for it
  // before any register write, since a write item leaves nothing to wait on.
  localparam int SETTLE_CYCLES = 100;
  // Upper bound on the whole run, the map fill included.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int TILE_SHIFT = $clog2(TILE_PIX);

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic result_strobe;
  res_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tile_map_viewport_walker i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow of the block: its tile map, its register file and the column at
  // which the last row walk stopped.
  logic [TILE_BITS-1:0] map_shadow [MAP_DEPTH];
  cfg_t                 view_cfg;
  logic [15:0]          walker_col;

  cmd_t cmd_q[$];
  res_t pending_results[$];
  int   queued_count;
  int   accepted_count;
  int   sender_idle_pct;
  int   fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog: nothing correct gets anywhere near this.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Tile coordinates wrap by keeping their low bits, the map sizes being
  // powers of two; this is floor modulo for negative coordinates as well.
  function automatic int map_addr(input logic [15:0] col, input logic [15:0] row);
    return int'({row[ROW_W-1:0], col[COL_W-1:0]});
  endfunction

  // Works out the result items that one accepted item causes and queues them.
  task automatic forecast_results(input cmd_t c);
    int scr_x, scr_y, vw, vh, scx, scy;
    int i, j, n, x0, x1, x2, y0, y1, y2;
    logic [TILE_BITS-1:0] spr;
    res_t r;
    r = '0;
    case (c.operation)
      OP_WRITE: map_shadow[map_addr(c.tile_col, c.tile_row)] = c.tile_value;
      OP_READ: begin
        r.kind      = KIND_READ;
        r.read_tile = map_shadow[map_addr(c.tile_col, c.tile_row)];
        r.last      = 1'b1;
        pending_results.push_back(r);
      end
      OP_DRAW: begin
        scr_x = $signed(view_cfg.screen_x);
        scr_y = $signed(view_cfg.screen_y);
        vw    = int'(view_cfg.view_width);
        vh    = int'(view_cfg.view_height);
        scx   = $signed(view_cfg.scroll_x);
        scy   = $signed(view_cfg.scroll_y);
        // Map row: first visible tile row plus the requested viewport row.
        j = (scy >>> TILE_SHIFT) + int'(c.view_row);
        n = 0;
        if (TILE_PIX * j < vh + scy) begin
          y0 = TILE_PIX * j - scy;
          y1 = (y0 < 0) ? 0 : y0;
          y2 = TILE_PIX * (j + 1) - scy;
          if (y2 >= vh) y2 = vh;
          for (i = scx >>> TILE_SHIFT; TILE_PIX * i < vw + scx && n < MAX_ROW_RECTS; i++) begin
            spr = map_shadow[map_addr(i[15:0], j[15:0])];
            if (spr != EMPTY_TILE) begin
              x0 = TILE_PIX * i - scx;
              x1 = (x0 < 0) ? 0 : x0;
              x2 = TILE_PIX * (i + 1) - scx;
              if (x2 >= vw) x2 = vw;
              r              = '0;
              r.kind         = KIND_RECT;
              r.dest_x       = 16'(scr_x + x1);
              r.dest_y       = 16'(scr_y + y1);
              r.sprite_index = spr;
              r.src_x        = 3'(x1 - x0);
              r.src_y        = 3'(y1 - y0);
              r.rect_w       = 4'(x2 - x1);
              r.rect_h       = 4'(y2 - y1);
              r.mask_out     = view_cfg.draw_mask;
              pending_results.push_back(r);
              n++;
            end
          end
          walker_col = i[15:0];
        end
        if (n == 0) begin
          // A row below the viewport, or one with only empty tiles.
          r      = '0;
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Presents queued items at the falling edge and takes them as accepted at
  // the rising edge where busy is low. After each item the sender may hold
  // off for a while, as the current idle percentage says.
  initial begin : cmd_driver
    int gap;
    gap   = 0;
    start = 1'b0;
    cmd   = '0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        gap--;
        start = 1'b0;
      end else if (cmd_q.size() != 0) begin
        start = 1'b1;
        cmd   = cmd_q[0];
      end else begin
        start = 1'b0;
      end
      @(posedge clk);
      if (start && busy === 1'b0) begin
        forecast_results(cmd);
        void'(cmd_q.pop_front());
        accepted_count++;
        if ($urandom_range(99) < sender_idle_pct) begin
          gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
        end
      end
    end
  end

  function automatic string describe(input res_t r);
    return $sformatf("kind=%0d read=%0d dx=%0d dy=%0d spr=%0d sx=%0d sy=%0d w=%0d h=%0d mask=%h last=%0d",
                     r.kind, r.read_tile, r.dest_x, r.dest_y, r.sprite_index,
                     r.src_x, r.src_y, r.rect_w, r.rect_h, r.mask_out, r.last);
  endfunction

  task automatic note_failure(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected %s, got %s", $realtime, what, describe(want), describe(got));
    end
  endtask

  // Each result item is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst === 1'b0 && result_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure("result with nothing expected", '0, result);
      end else begin
        want = pending_results.pop_front();
        if (result.kind !== want.kind || result.read_tile !== want.read_tile ||
            result.dest_x !== want.dest_x || result.dest_y !== want.dest_y ||
            result.sprite_index !== want.sprite_index || result.src_x !== want.src_x ||
            result.src_y !== want.src_y || result.rect_w !== want.rect_w ||
            result.rect_h !== want.rect_h || result.mask_out !== want.mask_out ||
            result.last !== want.last) begin
          note_failure("result mismatch", want, result);
        end
      end
    end
  end

  function automatic cmd_t make_cmd(input logic [1:0] op, input logic [15:0] col,
                                    input logic [15:0] row, input logic [7:0] val,
                                    input logic [5:0] vrow);
    cmd_t c;
    c.operation  = op;
    c.tile_col   = col;
    c.tile_row   = row;
    c.tile_value = val;
    c.view_row   = vrow;
    return c;
  endfunction

  // Hands one item to the driver and returns once the block has taken it.
  task automatic send_cmd(input cmd_t c);
    int ticket;
    ticket = queued_count;
    queued_count++;
    cmd_q.push_back(c);
    wait (accepted_count > ticket);
  endtask

  // Waits until every item is taken and every expected result has arrived.
  task automatic wait_drained;
    while (cmd_q.size() != 0 || pending_results.size() != 0) @(negedge clk);
  endtask

  // As above, then lets a trailing write or draw finish inside the block.
  task automatic settle_block;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SCREEN_X:    view_cfg.screen_x    = data[14:0];
      REG_SCREEN_Y:    view_cfg.screen_y    = data[14:0];
      REG_VIEW_WIDTH:  view_cfg.view_width  = data[8:0];
      REG_VIEW_HEIGHT: view_cfg.view_height = data[8:0];
      REG_SCROLL_X:    view_cfg.scroll_x    = data;
      REG_SCROLL_Y:    view_cfg.scroll_y    = data;
      REG_DRAW_MASK:   view_cfg.draw_mask   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Writes the whole register file. The bits above each register's width
  // carry junk, which the block must drop.
  task automatic apply_view(input logic [14:0] sx, input logic [14:0] sy,
                            input logic [8:0] vw, input logic [8:0] vh,
                            input logic [15:0] scx, input logic [15:0] scy,
                            input logic [15:0] mask);
    write_reg(REG_SCREEN_X,    {1'($urandom), sx});
    write_reg(REG_SCREEN_Y,    {1'($urandom), sy});
    write_reg(REG_VIEW_WIDTH,  {7'($urandom), vw});
    write_reg(REG_VIEW_HEIGHT, {7'($urandom), vh});
    write_reg(REG_SCROLL_X,    scx);
    write_reg(REG_SCROLL_Y,    scy);
    write_reg(REG_DRAW_MASK,   mask);
  endtask

  // The map is not cleared by reset, so map row 0 is written in full before
  // any read or draw; later reads and visible row draws stay on entries that
  // have been written. Coordinates carry random upper bits to exercise
  // wrapping; about a quarter of the tiles are empty.
  task automatic test_map_fill;
    logic [15:0] col, row;
    logic [7:0] val;
    for (int a = 0; a < MAP_COLS; a++) begin
      col = 16'($urandom);
      row = 16'($urandom);
      col[COL_W-1:0] = a[COL_W-1:0];
      row[ROW_W-1:0] = '0;
      val = ($urandom_range(3) == 0) ? EMPTY_TILE : 8'($urandom_range(0, 254));
      send_cmd(make_cmd(OP_WRITE, col, row, val, 6'($urandom)));
    end
  endtask

  // Extreme coordinates, aliasing through the wrap, and the unused code.
  task automatic test_tile_access;
    send_cmd(make_cmd(OP_WRITE, 16'h8000, 16'h8000, 8'h5A, 6'h00));
    send_cmd(make_cmd(OP_READ,  16'd128,  16'd256,  8'h00, 6'h3F));
    send_cmd(make_cmd(OP_WRITE, 16'h7FFF, 16'h7FFF, 8'hA5, 6'h3F));
    send_cmd(make_cmd(OP_READ,  16'hFFFF, 16'hFFFF, 8'hFF, 6'h00));
    send_cmd(make_cmd(OP_NONE,  16'hFFFF, 16'hFFFF, 8'h00, 6'h3F));
    send_cmd(make_cmd(OP_READ,  16'h7FFF, 16'hFF7F, 8'h00, 6'h00));
    send_cmd(make_cmd(OP_WRITE, 16'd5,    16'd3,    EMPTY_TILE, 6'h00));
    send_cmd(make_cmd(OP_READ,  16'd5,    16'd3,    8'h00, 6'h00));
  endtask

  // Row draws with the register values left by reset: the first visible
  // row, the first row below the viewport and the last row number.
  task automatic test_reset_view;
    send_cmd(make_cmd(OP_DRAW, 16'h0000, 16'h0000, 8'h00, 6'd0));
    send_cmd(make_cmd(OP_DRAW, 16'hFFFF, 16'hFFFF, 8'hFF, 6'd16));
    send_cmd(make_cmd(OP_DRAW, 16'h0000, 16'h0000, 8'h00, 6'd63));
  endtask

  task automatic test_view_edges;
    settle_block();
    write_reg(REG_UNUSED, 16'hFFFF);
    // One-tile viewport: an empty tile gives the empty-row marker, a filled
    // one a single full rectangle.
    apply_view(15'd0, 15'd0, 9'd8, 9'd8, 16'd0, 16'd0, 16'h1234);
    send_cmd(make_cmd(OP_WRITE, 16'd128, 16'd0, EMPTY_TILE, 6'd0));
    send_cmd(make_cmd(OP_DRAW,  16'd0,   16'd0, 8'h00, 6'd0));
    send_cmd(make_cmd(OP_WRITE, 16'd0,   16'd0, 8'h00, 6'd0));
    send_cmd(make_cmd(OP_DRAW,  16'd0,   16'd0, 8'h00, 6'd0));
    // Zero width with a small negative scroll still emits a zero-wide tile.
    settle_block();
    apply_view(15'd0, 15'd0, 9'd0, 9'd8, -16'sd3, 16'd0, 16'h0001);
    send_cmd(make_cmd(OP_WRITE, 16'hFFFF, 16'd0, 8'h07, 6'd0));
    send_cmd(make_cmd(OP_DRAW,  16'd0,    16'd0, 8'h00, 6'd0));
    // Largest viewport at the far corners of screen and scroll range. Map
    // row 0 shows at viewport row 0 in the first setting and at row 1 in the
    // second; viewport row 63 of the first lies just below the viewport.
    settle_block();
    apply_view(15'h4000, 15'h3FFF, 9'd504, 9'd504, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_cmd(make_cmd(OP_DRAW, 16'd0, 16'd0, 8'h00, 6'd0));
    send_cmd(make_cmd(OP_DRAW, 16'd0, 16'd0, 8'h00, 6'd63));
    settle_block();
    apply_view(15'h3FFF, 15'h4000, 9'd504, 9'd504, 16'h8000, 16'h7FFF, 16'h0000);
    send_cmd(make_cmd(OP_DRAW, 16'd0, 16'd0, 8'h00, 6'd1));
  endtask

  // Picks a viewport setting, weighted towards the edges of each range.
  // The vertical scroll always puts map row 0 within the first 64 rows of
  // the viewport.
  task automatic randomise_view;
    logic [14:0] sx, sy;
    logic [8:0] vw, vh;
    logic [15:0] scx, scy, mask;
    case ($urandom_range(3))
      0: sx = 15'h4000;
      1: sx = 15'h3FFF;
      default: sx = 15'($urandom);
    endcase
    case ($urandom_range(3))
      0: sy = 15'h4000;
      1: sy = 15'h3FFF;
      default: sy = 15'($urandom);
    endcase
    case ($urandom_range(4))
      0: vw = 9'd0;
      1: vw = 9'd504;
      2: vw = 9'($urandom_range(1, 16));
      default: vw = 9'($urandom_range(0, 504));
    endcase
    case ($urandom_range(4))
      0: vh = 9'd0;
      1: vh = 9'd504;
      2: vh = 9'($urandom_range(1, 16));
      default: vh = 9'($urandom_range(0, 504));
    endcase
    case ($urandom_range(3))
      0: scx = 16'h8000;
      1: scx = 16'h7FFF;
      default: scx = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: scy = 16'h8000;
      1: scy = 16'h7FFF;
      default: begin
        scy = 16'($urandom);
        scy[ROW_W+2:3] = ROW_W'(MAP_ROWS - int'($urandom_range(0, 63)));
      end
    endcase
    case ($urandom_range(2))
      0: mask = 16'h0000;
      1: mask = 16'hFFFF;
      default: mask = 16'($urandom);
    endcase
    apply_view(sx, sy, vw, vh, scx, scy, mask);
  endtask

  // Random mix of writes, reads, draws and unused codes. Reads stay on map row 0, and a
  // draw names either the viewport row that shows map row 0 or a row below
  // the viewport, so nothing unwritten is ever looked at.
  task automatic test_random_walks;
    int idle_pct [3];
    int roll, sent, sub, vh, fill_vrow, first_hidden;
    logic fill_visible;
    logic [5:0] vrow;
    logic [7:0] val;
    logic [15:0] row;
    idle_pct = '{28, 58, 0};
    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 4; blk++) begin
        settle_block();
        sender_idle_pct = idle_pct[ph];
        randomise_view();
        sub          = int'(view_cfg.scroll_y[2:0]);
        vh           = int'(view_cfg.view_height);
        fill_vrow    = (MAP_ROWS - int'(view_cfg.scroll_y[ROW_W+2:3])) % MAP_ROWS;
        fill_visible = (TILE_PIX * fill_vrow - sub < vh);
        // Smallest viewport row whose top edge is at or below the bottom.
        first_hidden = (vh + sub + TILE_PIX - 1) / TILE_PIX;
        sent = 0;
        while (sent < 5) begin
          roll = $urandom_range(99);
          if ($urandom_range(99) < 3) wait_drained();
          if (roll < 5) begin
            send_cmd(make_cmd(OP_NONE, 16'($urandom), 16'($urandom), 8'($urandom),
                              6'($urandom)));
          end else begin
            if (roll < 30) begin
              val = ($urandom_range(3) == 0) ? EMPTY_TILE : 8'($urandom);
              row = 16'($urandom);
              if ($urandom_range(1) == 0) row[ROW_W-1:0] = '0;
              send_cmd(make_cmd(OP_WRITE, 16'($urandom), row, val, 6'($urandom)));
            end else if (roll < 50) begin
              row = 16'($urandom);
              row[ROW_W-1:0] = '0;
              send_cmd(make_cmd(OP_READ, 16'($urandom), row, 8'($urandom),
                                6'($urandom)));
            end else begin
              if (fill_visible && (first_hidden > 63 || $urandom_range(3) != 0)) begin
                vrow = 6'(fill_vrow);
              end else begin
                vrow = 6'($urandom_range(first_hidden, 63));
              end
              send_cmd(make_cmd(OP_DRAW, 16'($urandom), 16'($urandom), 8'($urandom),
                                vrow));
            end
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    queued_count    = 0;
    accepted_count  = 0;
    fail_count      = 0;
    sender_idle_pct = 0;
    walker_col      = '0;
    view_cfg        = '{screen_x: '0, screen_y: '0, view_width: 9'd128,
                        view_height: 9'd128, scroll_x: '0, scroll_y: '0, draw_mask: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_map_fill();
    sender_idle_pct = 28;
    test_tile_access();
    test_reset_view();
    test_view_edges();
    test_random_walks();

    settle_block();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
design/tmvw_pkg.sv
design/tmvw_ram.sv
design/tmvw_walker.sv
design/tile_map_viewport_walker.sv
tb/tb_top.sv
